@@ rtl/lrgr_pkg.sv @@
// lrgr_pkg: shared types, constants and state encoding for the ground removal core.
// No dependencies.
`timescale 1ns / 1ps
package lrgr_pkg;

  localparam int COORD_BITS = 20;
  localparam int BIN_DEPTH  = 64;
  localparam int BIN_AW     = 6;
  localparam int DIST_BITS  = 20;
  localparam int HITS_BITS  = 16;
  localparam int CNT_BITS   = 7;
  localparam int CFG_BITS   = 19;
  localparam int SQ_BITS    = 2 * COORD_BITS + 2;
  localparam int ROOT_STEPS = SQ_BITS / 2;

  localparam logic [1:0] REG_LATERAL = 2'd0;
  localparam logic [1:0] REG_TOL     = 2'd1;
  localparam logic [1:0] REG_SLOW    = 2'd2;
  localparam logic [1:0] REG_SHIGH   = 2'd3;

  typedef struct packed {
    logic                          func;
    logic signed [COORD_BITS-1:0]  x_pos;
    logic signed [COORD_BITS-1:0]  y_pos;
    logic signed [COORD_BITS-1:0]  z_pos;
    logic                          last_point;
  } in_beat_t;

  typedef struct packed {
    logic                          is_obstacle;
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_y;
    logic signed [COORD_BITS-1:0]  out_z;
    logic [DIST_BITS-1:0]          peak_distance;
    logic [HITS_BITS-1:0]          peak_count;
    logic [CNT_BITS-1:0]           bins_used;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROOT, ST_CHECK, ST_SCAN_RD, ST_SCAN_EV, ST_DIV, ST_WR,
    ST_OPEN, ST_PEAK_RD, ST_PEAK_EV, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic root_step;
    logic check;
    logic scan_rd;
    logic scan_ev;
    logic div_start;
    logic div_step;
    logic bin_wr;
    logic bin_open;
    logic peak_init;
    logic peak_rd;
    logic peak_ev;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic func;
    logic last;
    logic eligible;
    logic scan_end;
    logic match;
    logic div_done;
    logic any_hit;
    logic peak_end;
  } status_t;

endpackage

@@ rtl/lrgr_ctrl.sv @@
// lrgr_ctrl: sequencer for one point: root, eligibility, bin walk, peak search.
// Depends on lrgr_pkg.
`timescale 1ns / 1ps
module lrgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lrgr_pkg::status_t sts,
  output lrgr_pkg::cmd_t    cmd
);

  lrgr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrgr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrgr_pkg::ST_IDLE:    if (start) state_nxt = lrgr_pkg::ST_ROOT;
      lrgr_pkg::ST_ROOT:    if (sts.root_done) state_nxt = lrgr_pkg::ST_CHECK;
      lrgr_pkg::ST_CHECK: begin
        if (sts.func || !sts.eligible) begin
          state_nxt = (!sts.func && sts.last) ? lrgr_pkg::ST_PEAK_RD : lrgr_pkg::ST_DONE;
        end else begin
          state_nxt = lrgr_pkg::ST_SCAN_RD;
        end
      end
      lrgr_pkg::ST_SCAN_RD: begin
        if (sts.scan_end) begin
          state_nxt = lrgr_pkg::ST_OPEN;
        end else begin
          state_nxt = lrgr_pkg::ST_SCAN_EV;
        end
      end
      lrgr_pkg::ST_SCAN_EV: state_nxt = sts.match ? lrgr_pkg::ST_DIV : lrgr_pkg::ST_SCAN_RD;
      lrgr_pkg::ST_DIV:     if (sts.div_done) state_nxt = lrgr_pkg::ST_WR;
      lrgr_pkg::ST_WR:      state_nxt = lrgr_pkg::ST_SCAN_RD;
      lrgr_pkg::ST_OPEN:    state_nxt = sts.last ? lrgr_pkg::ST_PEAK_RD : lrgr_pkg::ST_DONE;
      lrgr_pkg::ST_PEAK_RD: state_nxt = sts.peak_end ? lrgr_pkg::ST_DONE : lrgr_pkg::ST_PEAK_EV;
      lrgr_pkg::ST_PEAK_EV: state_nxt = lrgr_pkg::ST_PEAK_RD;
      lrgr_pkg::ST_DONE:    state_nxt = lrgr_pkg::ST_IDLE;
      default:              state_nxt = lrgr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != lrgr_pkg::ST_IDLE);
    case (state_r)
      lrgr_pkg::ST_IDLE:    cmd.load = start;
      lrgr_pkg::ST_ROOT:    cmd.root_step = 1'b1;
      lrgr_pkg::ST_CHECK: begin
        cmd.check     = 1'b1;
        cmd.peak_init = !sts.func && sts.last && (sts.func || !sts.eligible);
      end
      lrgr_pkg::ST_SCAN_RD: cmd.scan_rd = 1'b1;
      lrgr_pkg::ST_SCAN_EV: begin
        cmd.scan_ev   = 1'b1;
        cmd.div_start = sts.match;
      end
      lrgr_pkg::ST_DIV:     cmd.div_step = 1'b1;
      lrgr_pkg::ST_WR:      cmd.bin_wr = 1'b1;
      lrgr_pkg::ST_OPEN: begin
        cmd.bin_open  = !sts.any_hit;
        cmd.peak_init = sts.last;
      end
      lrgr_pkg::ST_PEAK_RD: cmd.peak_rd = 1'b1;
      lrgr_pkg::ST_PEAK_EV: cmd.peak_ev = 1'b1;
      lrgr_pkg::ST_DONE:    cmd.finish = 1'b1;
      default:              cmd = '0;
    endcase
  end

endmodule

@@ rtl/lrgr_dp.sv @@
// lrgr_dp: datapath with bin memory, serial square root, serial divider and peak search.
// Depends on lrgr_pkg.
`timescale 1ns / 1ps
module lrgr_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lrgr_pkg::cmd_t                     cmd,
  output lrgr_pkg::status_t                  sts,
  input  lrgr_pkg::in_beat_t                 in_data,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_idx,
  input  logic [lrgr_pkg::CFG_BITS-1:0]      cfg_data,
  output logic                               out_valid,
  output lrgr_pkg::out_beat_t                out_data
);

  localparam int CB = lrgr_pkg::COORD_BITS;
  localparam int SB = lrgr_pkg::SQ_BITS;
  localparam int DB = lrgr_pkg::DIST_BITS;
  localparam int HB = lrgr_pkg::HITS_BITS;
  localparam int AW = lrgr_pkg::BIN_AW;
  localparam int NB = DB + HB + 1;   // dividend width

  // configuration
  logic [18:0]        lat_r;
  logic [11:0]        tol_r;
  logic signed [15:0] slow_r, shigh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r   <= 19'd1536;
      tol_r   <= 12'd61;
      slow_r  <= -16'sd7427;
      shigh_r <= -16'sd7315;
    end else if (cfg_we) begin
      case (cfg_idx)
        lrgr_pkg::REG_LATERAL: lat_r   <= cfg_data;
        lrgr_pkg::REG_TOL:     tol_r   <= cfg_data[11:0];
        lrgr_pkg::REG_SLOW:    slow_r  <= cfg_data[15:0];
        lrgr_pkg::REG_SHIGH:   shigh_r <= cfg_data[15:0];
        default:               lat_r   <= lat_r;
      endcase
    end
  end

  // item capture; squared magnitude built over the first root steps
  lrgr_pkg::in_beat_t item_r;
  logic               pre_r;
  logic [SB-1:0]      rem_r, res_r, bit_r;
  logic [5:0]         step_r;
  logic [1:0]         sq_ph_r;
  logic [CB-1:0]      ax, ay, az, sel_mag;
  logic [2*CB-1:0]    sq_prod;

  always_comb begin
    ax = item_r.x_pos[CB-1] ? CB'(-item_r.x_pos) : CB'(item_r.x_pos);
    ay = item_r.y_pos[CB-1] ? CB'(-item_r.y_pos) : CB'(item_r.y_pos);
    az = item_r.z_pos[CB-1] ? CB'(-item_r.z_pos) : CB'(item_r.z_pos);
    case (sq_ph_r)
      2'd0:    sel_mag = ax;
      2'd1:    sel_mag = ay;
      default: sel_mag = az;
    endcase
    sq_prod = sel_mag * sel_mag;
  end

  logic [SB-1:0] trial;
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r   <= 1'b0;
      step_r  <= '0;
      sq_ph_r <= '0;
    end else if (cmd.load) begin
      pre_r   <= 1'b1;
      sq_ph_r <= '0;
      step_r  <= '0;
    end else if (cmd.root_step) begin
      if (pre_r) begin
        sq_ph_r <= sq_ph_r + 2'd1;
        if (sq_ph_r == 2'd2) pre_r <= 1'b0;
      end else begin
        step_r <= step_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      rem_r  <= '0;
      res_r  <= '0;
      bit_r  <= SB'(1) << (SB - 2);
    end else if (cmd.root_step) begin
      if (pre_r) begin
        rem_r <= rem_r + SB'(sq_prod);
      end else begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign sts.root_done = !pre_r && (step_r == 6'(lrgr_pkg::ROOT_STEPS - 1));
  assign sts.func      = item_r.func;
  assign sts.last      = item_r.last_point;

  // eligibility, evaluated in CHECK (root done); result and distance registered there
  logic [DB-1:0] d;
  assign d = (res_r > SB'({DB{1'b1}})) ? {DB{1'b1}} : res_r[DB-1:0];

  logic geo_ok;
  assign geo_ok = !item_r.x_pos[CB-1] && (item_r.x_pos != '0) && item_r.z_pos[CB-1]
                  && ({1'b0, ay} < {1'b0, (CB)'(lat_r)});

  logic signed [DB+16:0] lowp, highp, zs;
  assign lowp  = slow_r * $signed({1'b0, d});
  assign highp = shigh_r * $signed({1'b0, d});
  assign zs    = (DB+17)'($signed(item_r.z_pos)) <<< 15;

  logic elig_r;
  logic [DB-1:0] d_r;
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      elig_r <= geo_ok && (zs > lowp) && (zs < highp);
      d_r    <= d;
    end
  end
  assign sts.eligible = geo_ok && (zs > lowp) && (zs < highp);

  // bin memory
  logic [DB-1:0] center_mem [lrgr_pkg::BIN_DEPTH];
  logic [HB-1:0] hits_mem   [lrgr_pkg::BIN_DEPTH];
  logic [DB-1:0] rd_center_r;
  logic [HB-1:0] rd_hits_r;
  logic [lrgr_pkg::CNT_BITS-1:0] open_r, idx_r;
  logic          any_hit_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DB-1:0] wr_center;
  logic [HB-1:0] wr_hits;
  logic [DB-1:0] q_r;

  always_comb begin
    wr_en     = cmd.bin_wr || (cmd.bin_open && (open_r < 7'(lrgr_pkg::BIN_DEPTH)));
    wr_addr   = cmd.bin_wr ? idx_r[AW-1:0] : open_r[AW-1:0];
    wr_center = cmd.bin_wr ? q_r : d_r;
    wr_hits   = cmd.bin_wr ? ((rd_hits_r == {HB{1'b1}}) ? rd_hits_r : rd_hits_r + HB'(1))
                           : HB'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      center_mem[wr_addr] <= wr_center;
      hits_mem[wr_addr]   <= wr_hits;
    end
    rd_center_r <= center_mem[idx_r[AW-1:0]];
    rd_hits_r   <= hits_mem[idx_r[AW-1:0]];
  end

  // bin walk index; held on a matching bin until its write-back
  logic scan_rd_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      any_hit_r   <= 1'b0;
      open_r      <= '0;
      scan_rd_d_r <= 1'b0;
    end else begin
      scan_rd_d_r <= cmd.scan_rd || cmd.peak_rd;
      if (cmd.check || cmd.peak_init) begin
        idx_r     <= '0;
      end else if ((cmd.scan_ev && !sts.match) || cmd.bin_wr || cmd.peak_ev) begin
        idx_r     <= idx_r + 7'd1;
      end
      if (cmd.check) any_hit_r <= 1'b0;
      else if (cmd.bin_wr) any_hit_r <= 1'b1;
      if (wr_en && cmd.bin_open) open_r <= open_r + 7'd1;
      else if (cmd.finish && item_r.func && item_r.last_point) open_r <= '0;
    end
  end

  assign sts.scan_end = (idx_r >= open_r);
  assign sts.peak_end = (idx_r >= open_r);
  assign sts.any_hit  = any_hit_r;

  logic [DB:0] lo_b, hi_b;
  assign lo_b = {1'b0, rd_center_r} - (DB+1)'(tol_r);
  assign hi_b = {1'b0, rd_center_r} + (DB+1)'(tol_r);
  assign sts.match = (rd_center_r < (DB)'(tol_r) || {1'b0, d_r} >= lo_b)
                     && ({1'b0, d_r} <= hi_b);

  // running average divider: one quotient bit per cycle
  logic [NB-1:0]   num_r;
  logic [HB:0]     den_r;
  logic [NB:0]     prem_r;
  logic [5:0]      dcnt_r;
  logic [HB+DB:0]  hprod;
  logic [NB:0]     shrem;

  assign hprod = rd_hits_r * rd_center_r;
  assign shrem = {prem_r[NB-1:0], num_r[NB-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r  <= NB'(hprod) + NB'(d_r) + NB'(({1'b0, rd_hits_r} + 17'd1) >> 1);
      den_r  <= {1'b0, rd_hits_r} + 17'd1;
      prem_r <= '0;
      dcnt_r <= '0;
      q_r    <= '0;
    end else if (cmd.div_step) begin
      num_r  <= num_r << 1;
      dcnt_r <= dcnt_r + 6'd1;
      if (shrem >= (NB+1)'(den_r)) begin
        prem_r <= shrem - (NB+1)'(den_r);
        q_r    <= {q_r[DB-2:0], 1'b1};
      end else begin
        prem_r <= shrem;
        q_r    <= {q_r[DB-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = (dcnt_r == 6'(NB - 1)) && cmd.div_step;

  // peak search and winner
  logic [DB-1:0] wc_r;
  logic [HB-1:0] wh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0;
      wh_r <= '0;
    end else if (cmd.peak_init) begin
      wc_r <= '0;
      wh_r <= '0;
    end else if (cmd.peak_ev && scan_rd_d_r && (rd_hits_r > wh_r)) begin
      wc_r <= rd_center_r;
      wh_r <= rd_hits_r;
    end
  end

  // classify and result
  logic [DB:0] dl, dh, wlo, whi;
  logic        inside_band;
  always_comb begin
    dl  = {1'b0, d_r};
    dh  = {1'b0, d_r};
    wlo = {1'b0, wc_r} - (DB+1)'(tol_r);
    whi = {1'b0, wc_r} + (DB+1)'(tol_r);
    inside_band = ((wc_r < DB'(tol_r)) || (dl > wlo)) && (dh < whi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.is_obstacle   <= item_r.func && elig_r && !inside_band;
      out_data.out_x         <= item_r.x_pos;
      out_data.out_y         <= item_r.y_pos;
      out_data.out_z         <= item_r.z_pos;
      out_data.peak_distance <= wc_r;
      out_data.peak_count    <= wh_r;
      out_data.bins_used     <= (item_r.func && item_r.last_point) ? '0 : open_r;
    end
  end

endmodule

@@ rtl/lidar_ring_ground_removal_core.sv @@
// Ground removal core top level: controller plus datapath.
// Depends on lrgr_pkg, lrgr_ctrl, lrgr_dp.
//
// Usage: the host streams each frame twice. Pulse start with in_data while busy
// is low; in_data.func selects histogram (0) or classify (1) pass, last_point
// ends a pass. Exactly one result per item appears on out_data with out_valid
// high for one cycle; the receiver cannot stall, so the block never waits.
// Processing: the squared magnitude is accumulated axis by axis, then 21
// root steps find the distance. An eligible histogram point then walks the
// open bins, and each matching bin runs the serial running-average divider;
// the last histogram item adds a peak search over the open bins. One item at
// a time: busy stays high from acceptance until the result beat.
// Configuration: cfg_we, cfg_idx, cfg_data write one register per cycle; the
// host must write only while idle; the block does not enforce it. Synchronous
// active-low reset clears bin count, winner and controller; bin RAM needs none.
`timescale 1ns / 1ps
module lidar_ring_ground_removal_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lrgr_pkg::in_beat_t            in_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [lrgr_pkg::CFG_BITS-1:0] cfg_data,
  output logic                          out_valid,
  output lrgr_pkg::out_beat_t           out_data
);

  lrgr_pkg::cmd_t    cmd;
  lrgr_pkg::status_t sts;

  lrgr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lrgr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/lrgr_checker.sv @@
// lrgr_checker: port-level checks on the ground removal core, bound to the top.
// Depends on lrgr_pkg.
`timescale 1ns / 1ps
module lrgr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input lrgr_pkg::out_beat_t out_data
);

  // a beat is accepted only when idle, and busy follows
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // result beat only ends a busy period
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");

  // single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  a_bins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.bins_used <= 7'(lrgr_pkg::BIN_DEPTH)))
    else $error("bin count out of range");

endmodule

bind lidar_ring_ground_removal_core lrgr_checker u_lrgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
